// ===== hdl/cmic_pkg.sv =====
// ----------------------------------------------------------------------------
// cmic_pkg
// Types, constants and helpers for the compass motor interference cal core.
// ----------------------------------------------------------------------------
package cmic_pkg;

    localparam int IN_BITS    = 176;
    localparam int OUT_BITS   = 112;
    localparam int USER_BITS  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [9:0]  THR_FULL   = 10'd1000;
    localparam logic [31:0] K_THR      = 32'd1000;
    localparam logic [31:0] K_CUR      = 32'd100;
    localparam logic [31:0] K_INTF     = 32'd10000;
    localparam logic [31:0] K_SCALE    = 32'd100000;
    localparam logic [41:0] DIV_CONST  = 42'd100;
    localparam logic [15:0] SAT16      = 16'hFFFF;
    localparam logic [5:0]  DIV_LAST   = 6'd63;
    localparam logic [5:0]  SQ_LAST    = 6'd31;
    localparam logic [1:0]  AX_LAST    = 2'd2;

    localparam logic signed [63:0] I32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] I32_MIN = -64'sh0000_0000_8000_0000;

    typedef enum logic [1:0] {
        REG_COMP_MODE     = 2'd0,
        REG_COMPASS_COUNT = 2'd1,
        REG_CUR_THRESH    = 2'd2,
        REG_EXP_FIELD     = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TICK_SEED,
        TICK_BASE,
        TICK_ACT
    } tick_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DEC,
        ST_AX,
        ST_MUL1,
        ST_MUL2,
        ST_DIVSET,
        ST_DIV,
        ST_AXWB,
        ST_LSET,
        ST_LMUL,
        ST_SQSET,
        ST_SQ,
        ST_ILEN,
        ST_INUM,
        ST_IDEN,
        ST_ICHK,
        ST_ISCALE,
        ST_IWB,
        ST_OUT,
        ST_WAIT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > I32_MAX)
            r = 32'sh7FFF_FFFF;
        else if (v < I32_MIN)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hdl/compass_motor_interference_cal_core.sv =====
// ----------------------------------------------------------------------------
// compass_motor_interference_cal_core
// Motor interference calibration over up to three compasses, bit-serial math.
// ----------------------------------------------------------------------------
// channel | dir | handshake               | payload
// s_axis  | in  | s_axis_tvalid/tready    | tdata: 9 fields, throttle, current
// m_axis  | out | m_axis_tvalid/tready    | tdata: comp xyz, interference;
//         |     |                         | tuser: index, valid; tlast
// cfg     | in  | cfg_we                  | cfg_index, cfg_data
//
// One tick at a time. A seeding tick passes the decode state, then an output and
// a wait state per result. In an updated compass each divide is 64 steps of the
// shared bit-serial divider, each multiply takes one multiplier bit per cycle,
// and the root 32 steps.
// Reset clears all calibration state. A stalled result holds the core.
// ----------------------------------------------------------------------------
module compass_motor_interference_cal_core #(
    parameter int NUM_COMPASSES = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // x0,y0,z0,x1,y1,z1,x2,y2,z2 (16 each), throttle_in (10), current_ca (16)
    input  logic [cmic_pkg::IN_BITS-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // comp_x (32), comp_y (32), comp_z (32), interference (16)
    output logic [cmic_pkg::OUT_BITS-1:0]  m_axis_tdata,
    // compass_index (2), comp_valid (1)
    output logic [cmic_pkg::USER_BITS-1:0] m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           cfg_we,
    input  logic [cmic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cmic_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cmic_pkg::*;

    localparam int IXW = (NUM_COMPASSES > 1) ? $clog2(NUM_COMPASSES) : 1;

    state_t state_reg, state_next;
    tick_t  kind_reg;

    logic              mode_reg;
    logic [1:0]        cnt_reg;
    logic [15:0]       thresh_reg;
    logic [15:0]       ef_reg;

    logic signed [15:0] fld_reg [9];
    logic [9:0]        thr_reg;
    logic [15:0]       cur_reg;

    logic signed [31:0] base_reg [NUM_COMPASSES][3];
    logic signed [31:0] comp_reg [NUM_COMPASSES][3];
    logic [15:0]       intf_reg [NUM_COMPASSES];
    logic              seeded_reg;
    logic              ever_reg;
    logic [9:0]        tpk_reg;
    logic [15:0]       cpk_reg;

    logic              upd_reg;
    logic              iph_reg;
    logic [1:0]        idx_reg;
    logic [1:0]        ax_reg;
    logic [5:0]        step_reg;

    logic [63:0]       mcand_reg;
    logic [31:0]       mplier_reg;
    logic [63:0]       prod_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       num_reg;
    logic [41:0]       dsor_reg;
    logic [41:0]       den_reg;
    logic              neg_reg;
    logic [63:0]       dvd_reg;
    logic [41:0]       rem_reg;
    logic [63:0]       rad_reg;
    logic [35:0]       sqrem_reg;
    logic [31:0]       root_reg;

    logic                 out_valid_reg;
    logic [OUT_BITS-1:0]  out_data_reg;
    logic [USER_BITS-1:0] out_user_reg;
    logic                 out_last_reg;

    logic [1:0]        n_eff;
    logic              is_last;
    logic [3:0]        fidx;
    logic signed [15:0] fsel;
    logic signed [31:0] base_cur, comp_cur;
    logic signed [63:0] imp, delta, wb_sum, sat_s, num_abs;
    logic [15:0]       m1;
    logic [22:0]       d100;
    logic              upd_c, mul_done, cur_zero, ichk_zero, ichk_sat;
    logic [31:0]       comp_abs;
    logic [42:0]       rsh;
    logic [43:0]       rdiff;
    logic [35:0]       sq_sh, sq_trial;

    always_comb
    begin
        if (cnt_reg == 2'd0)
            n_eff = 2'd1;
        else if (32'(cnt_reg) > NUM_COMPASSES)
            n_eff = 2'(NUM_COMPASSES);
        else
            n_eff = cnt_reg;
        is_last  = (idx_reg == n_eff - 2'd1);
        fidx     = 4'(idx_reg) * 4'd3 + 4'(ax_reg);
        fsel     = fld_reg[fidx];
        base_cur = base_reg[idx_reg[IXW-1:0]][ax_reg];
        comp_cur = comp_reg[idx_reg[IXW-1:0]][ax_reg];
        imp      = {{32{fsel[15]}}, fsel, 16'h0000} - {{32{base_cur[31]}}, base_cur};
        m1       = mode_reg ? cur_reg : {6'b0, thr_reg};
        d100     = 23'(m1) * 23'd100;
        upd_c    = !mode_reg || (cur_reg >= thresh_reg);
        cur_zero = mode_reg && (cur_reg == 16'd0);
        mul_done = (mplier_reg == 32'd0);
        delta    = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);
        if (kind_reg == TICK_BASE)
            wb_sum = {{32{base_cur[31]}}, base_cur} + delta;
        else
            wb_sum = {{32{comp_cur[31]}}, comp_cur} - delta;
        if (imp > 64'sd0)
            sat_s = I32_MAX;
        else if (imp < 64'sd0)
            sat_s = I32_MIN;
        else
            sat_s = 64'sd0;
        num_abs   = num_reg[63] ? -$signed(num_reg) : $signed(num_reg);
        comp_abs  = comp_cur[31] ? 32'(-comp_cur) : 32'(comp_cur);
        ichk_zero = (num_reg == 64'd0);
        ichk_sat  = (den_reg == 42'd0) || (mode_reg && (num_reg[63:47] != 17'd0));
        rsh       = {rem_reg, dvd_reg[63]};
        rdiff     = {1'b0, rsh} - {2'b00, dsor_reg};
        sq_sh     = {sqrem_reg[33:0], rad_reg[63:62]};
        sq_trial  = {2'b00, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                    state_next = ST_DEC;
            ST_DEC:
                if (!seeded_reg)
                    state_next = ST_OUT;
                else if (thr_reg == 10'd0 || upd_c)
                    state_next = ST_AX;
                else
                    state_next = ST_LSET;
            ST_AX:
                if (kind_reg == TICK_BASE || cur_zero)
                    state_next = ST_DIVSET;
                else
                    state_next = ST_MUL1;
            ST_MUL1:
                if (mul_done)
                    state_next = ST_MUL2;
            ST_MUL2:
                if (mul_done)
                    state_next = ST_DIVSET;
            ST_DIVSET:
                state_next = ST_DIV;
            ST_DIV:
                if (step_reg == DIV_LAST)
                    state_next = iph_reg ? ST_IWB : ST_AXWB;
            ST_AXWB:
                if (ax_reg == AX_LAST)
                    state_next = (kind_reg == TICK_BASE) ? ST_OUT : ST_LSET;
                else
                    state_next = ST_AX;
            ST_LSET:
                state_next = ST_LMUL;
            ST_LMUL:
                if (mul_done)
                    state_next = (ax_reg == AX_LAST) ? ST_SQSET : ST_LSET;
            ST_SQSET:
                state_next = ST_SQ;
            ST_SQ:
                if (step_reg == SQ_LAST)
                    state_next = ST_ILEN;
            ST_ILEN:
                state_next = ST_INUM;
            ST_INUM:
                if (mul_done)
                    state_next = mode_reg ? ST_IDEN : ST_ICHK;
            ST_IDEN:
                if (mul_done)
                    state_next = ST_ICHK;
            ST_ICHK:
                if (ichk_zero || ichk_sat)
                    state_next = ST_OUT;
                else if (mode_reg)
                    state_next = ST_ISCALE;
                else
                    state_next = ST_DIVSET;
            ST_ISCALE:
                if (mul_done)
                    state_next = ST_DIVSET;
            ST_IWB:
                state_next = ST_OUT;
            ST_OUT:
                state_next = ST_WAIT;
            ST_WAIT:
                if (m_axis_tready)
                begin
                    if (out_last_reg)
                        state_next = ST_IDLE;
                    else if (kind_reg == TICK_SEED)
                        state_next = ST_OUT;
                    else if (kind_reg == TICK_BASE || upd_reg)
                        state_next = ST_AX;
                    else
                        state_next = ST_LSET;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            cnt_reg       <= 2'd1;
            thresh_reg    <= 16'd300;
            ef_reg        <= 16'd530;
            seeded_reg    <= 1'b0;
            ever_reg      <= 1'b0;
            tpk_reg       <= '0;
            cpk_reg       <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= TICK_SEED;
            upd_reg       <= 1'b0;
            iph_reg       <= 1'b0;
            idx_reg       <= '0;
            ax_reg        <= '0;
            step_reg      <= '0;
            for (int i = 0; i < NUM_COMPASSES; i++)
            begin
                intf_reg[i] <= '0;
                for (int a = 0; a < 3; a++)
                begin
                    base_reg[i][a] <= '0;
                    comp_reg[i][a] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COMP_MODE:     mode_reg   <= cfg_data[0];
                    REG_COMPASS_COUNT: cnt_reg    <= cfg_data[1:0];
                    REG_CUR_THRESH:    thresh_reg <= cfg_data;
                    REG_EXP_FIELD:     ef_reg     <= cfg_data;
                    default:           mode_reg   <= mode_reg;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                    if (s_axis_tvalid)
                    begin
                        for (int i = 0; i < 9; i++)
                            fld_reg[i] <= s_axis_tdata[16*i +: 16];
                        thr_reg <= (s_axis_tdata[153:144] > THR_FULL) ? THR_FULL
                                                                      : s_axis_tdata[153:144];
                        cur_reg <= s_axis_tdata[169:154];
                    end
                ST_DEC:
                begin
                    idx_reg <= '0;
                    ax_reg  <= '0;
                    iph_reg <= 1'b0;
                    if (!seeded_reg)
                    begin
                        for (int i = 0; i < NUM_COMPASSES; i++)
                            for (int a = 0; a < 3; a++)
                                base_reg[i][a] <= {fld_reg[i*3+a], 16'h0000};
                        seeded_reg <= 1'b1;
                        kind_reg   <= TICK_SEED;
                    end
                    else if (thr_reg == 10'd0)
                        kind_reg <= TICK_BASE;
                    else
                    begin
                        kind_reg <= TICK_ACT;
                        upd_reg  <= upd_c;
                        if (upd_c)
                            ever_reg <= 1'b1;
                    end
                end
                ST_AX:
                    if (kind_reg == TICK_BASE)
                    begin
                        num_reg  <= imp;
                        dsor_reg <= DIV_CONST;
                    end
                    else if (cur_zero)
                    begin
                        num_reg  <= {{32{comp_cur[31]}}, comp_cur} + sat_s;
                        dsor_reg <= DIV_CONST;
                    end
                    else
                    begin
                        mcand_reg  <= {{32{comp_cur[31]}}, comp_cur};
                        mplier_reg <= 32'(m1);
                        prod_reg   <= '0;
                    end
                ST_MUL1:
                    if (mul_done)
                    begin
                        acc_reg    <= prod_reg;
                        mcand_reg  <= imp;
                        mplier_reg <= mode_reg ? K_CUR : K_THR;
                        prod_reg   <= '0;
                    end
                    else
                    begin
                        prod_reg   <= prod_reg + (mplier_reg[0] ? mcand_reg : 64'd0);
                        mcand_reg  <= {mcand_reg[62:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[31:1]};
                    end
                ST_MUL2:
                    if (mul_done)
                    begin
                        num_reg  <= acc_reg + prod_reg;
                        dsor_reg <= 42'(d100);
                    end
                    else
                    begin
                        prod_reg   <= prod_reg + (mplier_reg[0] ? mcand_reg : 64'd0);
                        mcand_reg  <= {mcand_reg[62:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[31:1]};
                    end
                ST_DIVSET:
                begin
                    rem_reg  <= '0;
                    step_reg <= '0;
                    if (iph_reg)
                    begin
                        neg_reg <= 1'b0;
                        dvd_reg <= num_reg + 64'(dsor_reg[41:1]);
                    end
                    else
                    begin
                        neg_reg <= num_reg[63];
                        dvd_reg <= num_abs + 64'(dsor_reg[41:1]);
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= rdiff[43] ? rsh[41:0] : rdiff[41:0];
                    dvd_reg  <= {dvd_reg[62:0], !rdiff[43]};
                    step_reg <= step_reg + 6'd1;
                end
                ST_AXWB:
                begin
                    if (kind_reg == TICK_BASE)
                        base_reg[idx_reg[IXW-1:0]][ax_reg] <= sat32(wb_sum);
                    else
                        comp_reg[idx_reg[IXW-1:0]][ax_reg] <= sat32(wb_sum);
                    ax_reg <= (ax_reg == AX_LAST) ? 2'd0 : ax_reg + 2'd1;
                end
                ST_LSET:
                begin
                    mcand_reg  <= 64'(comp_abs);
                    mplier_reg <= comp_abs;
                    prod_reg   <= '0;
                    if (ax_reg == 2'd0)
                        acc_reg <= '0;
                end
                ST_LMUL:
                    if (mul_done)
                    begin
                        acc_reg <= acc_reg + prod_reg;
                        ax_reg  <= (ax_reg == AX_LAST) ? 2'd0 : ax_reg + 2'd1;
                    end
                    else
                    begin
                        prod_reg   <= prod_reg + (mplier_reg[0] ? mcand_reg : 64'd0);
                        mcand_reg  <= {mcand_reg[62:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[31:1]};
                    end
                ST_SQSET:
                begin
                    rad_reg   <= acc_reg;
                    sqrem_reg <= '0;
                    root_reg  <= '0;
                    step_reg  <= '0;
                end
                ST_SQ:
                begin
                    if (sq_sh >= sq_trial)
                    begin
                        sqrem_reg <= sq_sh - sq_trial;
                        root_reg  <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        sqrem_reg <= sq_sh;
                        root_reg  <= {root_reg[30:0], 1'b0};
                    end
                    rad_reg  <= {rad_reg[61:0], 2'b00};
                    step_reg <= step_reg + 6'd1;
                end
                ST_ILEN:
                begin
                    mcand_reg  <= 64'(root_reg);
                    mplier_reg <= mode_reg ? 32'(cpk_reg) : K_INTF;
                    prod_reg   <= '0;
                    iph_reg    <= 1'b1;
                end
                ST_INUM:
                    if (mul_done)
                    begin
                        num_reg <= prod_reg;
                        if (mode_reg)
                        begin
                            mcand_reg  <= 64'(tpk_reg);
                            mplier_reg <= 32'(ef_reg);
                            prod_reg   <= '0;
                        end
                        else
                            den_reg <= 42'({ef_reg, 16'h0000});
                    end
                    else
                    begin
                        prod_reg   <= prod_reg + (mplier_reg[0] ? mcand_reg : 64'd0);
                        mcand_reg  <= {mcand_reg[62:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[31:1]};
                    end
                ST_IDEN:
                    if (mul_done)
                        den_reg <= {prod_reg[25:0], 16'h0000};
                    else
                    begin
                        prod_reg   <= prod_reg + (mplier_reg[0] ? mcand_reg : 64'd0);
                        mcand_reg  <= {mcand_reg[62:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[31:1]};
                    end
                ST_ICHK:
                begin
                    dsor_reg <= den_reg;
                    if (ichk_zero)
                        intf_reg[idx_reg[IXW-1:0]] <= '0;
                    else if (ichk_sat)
                        intf_reg[idx_reg[IXW-1:0]] <= SAT16;
                    else if (mode_reg)
                    begin
                        mcand_reg  <= num_reg;
                        mplier_reg <= K_SCALE;
                        prod_reg   <= '0;
                    end
                end
                ST_ISCALE:
                    if (mul_done)
                        num_reg <= prod_reg;
                    else
                    begin
                        prod_reg   <= prod_reg + (mplier_reg[0] ? mcand_reg : 64'd0);
                        mcand_reg  <= {mcand_reg[62:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[31:1]};
                    end
                ST_IWB:
                    intf_reg[idx_reg[IXW-1:0]] <= (dvd_reg[63:16] != 48'd0) ? SAT16
                                                                            : dvd_reg[15:0];
                ST_OUT:
                begin
                    out_data_reg  <= {intf_reg[idx_reg[IXW-1:0]],
                                      comp_reg[idx_reg[IXW-1:0]][2],
                                      comp_reg[idx_reg[IXW-1:0]][1],
                                      comp_reg[idx_reg[IXW-1:0]][0]};
                    out_user_reg  <= {ever_reg, idx_reg};
                    out_last_reg  <= is_last;
                    out_valid_reg <= 1'b1;
                end
                ST_WAIT:
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            if (kind_reg == TICK_ACT)
                            begin
                                if (thr_reg > tpk_reg)
                                    tpk_reg <= thr_reg;
                                if (cur_reg > cpk_reg)
                                    cpk_reg <= cur_reg;
                            end
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 2'd1;
                            ax_reg  <= '0;
                            iph_reg <= 1'b0;
                        end
                    end
                default:
                    iph_reg <= iph_reg;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken twice in a row");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after last result of a tick");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1:0] != 2'd3))
        else $error("compass index out of range");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the compass motor interference cal core against a behavioral model of
// seeding, base tracking, throttle and current compensation and interference,
// with random stalls on both stream ports and several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import cmic_pkg::*;

    typedef struct packed {
        logic [1:0]         idx;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [15:0]        intf;
        logic               cvalid;
        logic               last;
    } cal_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_BITS-1:0]     s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_BITS-1:0]    m_axis_tdata;
    logic [USER_BITS-1:0]   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    compass_motor_interference_cal_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // model state
    logic        md_mode;
    logic [1:0]  md_count;
    logic [15:0] md_thresh;
    logic [15:0] md_field;
    logic        md_seeded;
    logic signed [31:0] base_v [3][3];
    logic signed [31:0] comp_v [3][3];
    logic [15:0] intf_hold [3];
    logic [9:0]  thr_peak;
    logic [15:0] cur_peak;
    logic        ever_upd;

    cal_result_t expected_q[$];
    int          errors;
    int          results_seen;
    int          ticks_sent;
    bit          idle_en;
    int          stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint rnd_div(longint n, longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] next_comp(logic signed [31:0] comp, longint imp,
                                                     longint t, longint c, logic cur);
        longint cv, delta, s;
        cv = comp;
        if (!cur)
            delta = rnd_div(cv * t + imp * 1000, 100 * t);
        else if (c > 0)
            delta = rnd_div(cv * c + imp * 100, 100 * c);
        else
        begin
            s = imp > 0 ? 64'sd2147483647 : (imp < 0 ? -64'sd2147483648 : 0);
            delta = rnd_div(cv + s, 100);
        end
        return clip32(cv - delta);
    endfunction

    function automatic longint field_at(logic [IN_BITS-1:0] d, int k);
        logic signed [15:0] f;
        f = d[16*k +: 16];
        return longint'(f) * 65536;
    endfunction

    task automatic predict_tick(logic [IN_BITS-1:0] d);
        int n;
        longint t, c, imp;
        longint unsigned len, num, den;
        logic upd;
        cal_result_t r;
        n = md_count == 0 ? 1 : md_count;
        t = d[153:144];
        c = d[169:154];
        if (t > 1000)
            t = 1000;
        if (!md_seeded)
        begin
            for (int i = 0; i < 3; i++)
                for (int a = 0; a < 3; a++)
                    base_v[i][a] = 32'(field_at(d, 3*i + a));
            md_seeded = 1'b1;
        end
        else if (t == 0)
        begin
            for (int i = 0; i < n; i++)
                for (int a = 0; a < 3; a++)
                    base_v[i][a] = clip32(base_v[i][a]
                        + rnd_div(field_at(d, 3*i + a) - base_v[i][a], 100));
        end
        else
        begin
            upd = !md_mode || c >= md_thresh;
            for (int i = 0; i < n; i++)
            begin
                if (upd)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        imp = field_at(d, 3*i + a) - base_v[i][a];
                        comp_v[i][a] = next_comp(comp_v[i][a], imp, t, c, md_mode);
                    end
                    ever_upd = 1'b1;
                end
                len = 0;
                for (int a = 0; a < 3; a++)
                    len += longint'(comp_v[i][a]) * longint'(comp_v[i][a]);
                len = root64(len);
                if (!md_mode)
                begin
                    num = len * 10000;
                    den = longint'(md_field) * 65536;
                    if (num == 0)
                        intf_hold[i] = '0;
                    else if (den == 0)
                        intf_hold[i] = 16'hFFFF;
                    else
                        intf_hold[i] = ((num + den/2) / den) > 65535 ? 16'hFFFF
                                       : 16'((num + den/2) / den);
                end
                else
                begin
                    num = len * cur_peak;
                    den = longint'(thr_peak) * md_field * 65536;
                    if (num == 0)
                        intf_hold[i] = '0;
                    else if (den == 0 || num >= (64'd1 << 47))
                        intf_hold[i] = 16'hFFFF;
                    else
                        intf_hold[i] = ((num*100000 + den/2) / den) > 65535 ? 16'hFFFF
                                       : 16'((num*100000 + den/2) / den);
                end
            end
            if (t > thr_peak)
                thr_peak = 10'(t);
            if (c > cur_peak)
                cur_peak = 16'(c);
        end
        for (int i = 0; i < n; i++)
        begin
            r.idx    = 2'(i);
            r.cx     = comp_v[i][0];
            r.cy     = comp_v[i][1];
            r.cz     = comp_v[i][2];
            r.intf   = intf_hold[i];
            r.cvalid = ever_upd;
            r.last   = (i == n - 1);
            expected_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    always @(posedge clk)
    begin
        cal_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
                report_mismatch("unexpected transaction", m_axis_tdata[31:0], 0);
            else
            begin
                e = expected_q.pop_front();
                if (m_axis_tuser[1:0] != e.idx)
                    report_mismatch("compass_index", m_axis_tuser[1:0], e.idx);
                if (m_axis_tdata[31:0] != e.cx)
                    report_mismatch("comp_x", m_axis_tdata[31:0], e.cx);
                if (m_axis_tdata[63:32] != e.cy)
                    report_mismatch("comp_y", m_axis_tdata[63:32], e.cy);
                if (m_axis_tdata[95:64] != e.cz)
                    report_mismatch("comp_z", m_axis_tdata[95:64], e.cz);
                if (m_axis_tdata[111:96] != e.intf)
                    report_mismatch("interference", m_axis_tdata[111:96], e.intf);
                if (m_axis_tuser[2] != e.cvalid)
                    report_mismatch("comp_valid", m_axis_tuser[2], e.cvalid);
                if (m_axis_tlast != e.last)
                    report_mismatch("last_of_tick", m_axis_tlast, e.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!idle_en)
        begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= int'($urandom_range(0, 7));
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_tick(logic [IN_BITS-1:0] d);
        if (idle_en && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) @(posedge clk);
        else
            @(posedge clk);
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_tick(d);
        ticks_sent++;
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_COMP_MODE:     md_mode   = val[0];
            REG_COMPASS_COUNT: md_count  = val[1:0];
            REG_CUR_THRESH:    md_thresh = val;
            default:           md_field  = val;
        endcase
    endtask

    function automatic logic [IN_BITS-1:0] make_tick(int spread, int thr, int cur);
        logic [IN_BITS-1:0] d;
        d = '0;
        for (int k = 0; k < 9; k++)
            d[16*k +: 16] = 16'(300 + $urandom_range(0, 2*spread) - spread);
        d[153:144] = thr[9:0];
        d[169:154] = cur[15:0];
        return d;
    endfunction

    function automatic logic [IN_BITS-1:0] noise_tick();
        logic [IN_BITS-1:0] d;
        d = '0;
        for (int k = 0; k < 11; k++)
            d[16*k +: 16] = 16'($urandom());
        d[175:170] = '0;
        return d;
    endfunction

    task automatic test_directed_throttle;
        logic [IN_BITS-1:0] d;
        write_reg(REG_COMPASS_COUNT, 2'd3);
        send_tick(make_tick(20, 500, 100));
        send_tick(make_tick(50, 0, 0));
        send_tick(make_tick(50, 1, 0));
        send_tick(make_tick(50, 1000, 65535));
        send_tick(make_tick(50, 1023, 0));
        d = '0;
        for (int k = 0; k < 9; k++)
            d[16*k +: 16] = k[0] ? 16'h8000 : 16'h7FFF;
        d[153:144] = 10'd1;
        send_tick(d);
        d = ~d;
        d[175:144] = {6'd0, 16'hFFFF, 10'd1001};
        send_tick(d);
        send_tick(make_tick(50, 0, 0));
    endtask

    task automatic test_directed_current;
        drain();
        write_reg(REG_COMP_MODE, 1'b1);
        write_reg(REG_CUR_THRESH, 16'd0);
        write_reg(REG_EXP_FIELD, 16'd0);
        write_reg(REG_COMPASS_COUNT, 2'd0);
        send_tick(make_tick(50, 300, 0));
        send_tick(make_tick(50, 600, 1));
        send_tick(make_tick(50, 600, 65535));
        drain();
        write_reg(REG_CUR_THRESH, 16'hFFFF);
        write_reg(REG_EXP_FIELD, 16'hFFFF);
        write_reg(REG_COMPASS_COUNT, 2'd2);
        send_tick(make_tick(50, 400, 65534));
        send_tick(make_tick(50, 400, 65535));
        send_tick(make_tick(50, 0, 200));
    endtask

    task automatic test_random(logic mode, logic [1:0] cnt, logic [15:0] thr, logic [15:0] fld,
                               int count);
        drain();
        write_reg(REG_COMP_MODE, mode);
        write_reg(REG_COMPASS_COUNT, cnt);
        write_reg(REG_CUR_THRESH, thr);
        write_reg(REG_EXP_FIELD, fld);
        for (int j = 0; j < count; j++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_tick(noise_tick());
            else if ($urandom_range(0, 4) == 0)
                send_tick(make_tick(40, 0, $urandom_range(0, 65535)));
            else
                send_tick(make_tick($urandom_range(1, 400), $urandom_range(1, 1023),
                                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 3000)));
            if (j == count / 2)
                while (expected_q.size() != 0)
                    @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_COMP_MODE;
        cfg_data      = '0;
        errors        = 0;
        results_seen  = 0;
        ticks_sent    = 0;
        idle_en       = 1'b1;
        md_mode   = 1'b0;
        md_count  = 2'd1;
        md_thresh = 16'd300;
        md_field  = 16'd530;
        md_seeded = 1'b0;
        thr_peak  = '0;
        cur_peak  = '0;
        ever_upd  = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            intf_hold[i] = '0;
            for (int a = 0; a < 3; a++)
            begin
                base_v[i][a] = '0;
                comp_v[i][a] = '0;
            end
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_throttle();
        test_directed_current();
        test_random(1'b0, 2'd3, 16'd300, 16'd530, 50);
        test_random(1'b1, 2'd3, 16'd1000, 16'd1, 50);
        test_random(1'b0, 2'd1, 16'd0, 16'd65535, 40);
        idle_en = 1'b0;
        test_random(1'b1, 2'd2, 16'd500, 16'd400, 40);
        drain();
        $display("covered %0d ticks, %0d results, throttle and current modes, 0..3 compasses",
                 ticks_sent, results_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/cmic_pkg.sv
hdl/compass_motor_interference_cal_core.sv
sim/testbench.sv
